/* rtl/skvt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

  localparam int unsigned KEY_W        = 32;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned CAPACITY_DEF = 32;

  // operation codes
  localparam logic [1:0] OP_PUT = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_GET = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_WRITE,
    CMD_INSERT
  } cell_cmd_e;

  typedef enum logic [1:0] {
    STATE_IDLE,
    STATE_SEARCH,
    STATE_APPLY
  } ctrl_state_e;

  // command broadcast to every cell
  typedef struct packed {
    cell_cmd_e               cmd;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] val;
  } cell_cmd_t;

  // what a cell shows its upper neighbor
  typedef struct packed {
    logic                    occ;
    logic                    lt;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] val;
  } cell_link_t;

endpackage

`default_nettype wire

/* rtl/skvt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module skvt_cell
  import skvt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_cmd_t        cmd_i,
  input  wire cell_link_t       prev_i,
  output cell_link_t            link_o,
  output logic                  hit_o,
  output logic [VAL_W-1:0]      hit_val_o
);

  logic                    occ_q, occ_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic                    lt, eq;

  assign lt = occ_q && (key_q < cmd_i.key);
  assign eq = occ_q && (key_q == cmd_i.key);

  always_comb begin
    occ_d = occ_q;
    key_d = key_q;
    val_d = val_q;
    case (cmd_i.cmd)
      CMD_WRITE: begin
        if (eq) begin
          val_d = cmd_i.val;
        end
      end
      CMD_INSERT: begin
        // cells at or above the sorted place move up by one
        if (!lt) begin
          if (prev_i.lt) begin
            occ_d = 1'b1;
            key_d = cmd_i.key;
            val_d = cmd_i.val;
          end else begin
            occ_d = prev_i.occ;
            key_d = prev_i.key;
            val_d = prev_i.val;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  assign link_o    = '{occ: occ_q, lt: lt, key: key_q, val: val_q};
  assign hit_o     = eq;
  assign hit_val_o = eq ? val_q : '0;

endmodule

`default_nettype wire

/* rtl/skvt_tree.sv */
`timescale 1ns / 1ps
`default_nettype none

module skvt_tree
  import skvt_pkg::*;
#(
  parameter int unsigned N = CAPACITY_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [N-1:0]     hit_i,
  input  wire logic [VAL_W-1:0] val_i [N],
  output logic                  hit_o,
  output logic [VAL_W-1:0]      val_o
);

  localparam int unsigned LEAVES = 1 << $clog2(N);

  // heap order: node 1 is the root, leaves sit at LEAVES .. 2*LEAVES-1
  logic             node_hit_q [1:2*LEAVES-1];
  logic [VAL_W-1:0] node_val_q [1:2*LEAVES-1];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < N) begin : g_used
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          node_hit_q[LEAVES+i] <= 1'b0;
        end else begin
          node_hit_q[LEAVES+i] <= hit_i[i];
        end
      end
      always_ff @(posedge clk_i) begin
        node_val_q[LEAVES+i] <= val_i[i];
      end
    end else begin : g_pad
      // padding leaves never hit
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          node_hit_q[LEAVES+i] <= 1'b0;
        end else begin
          node_hit_q[LEAVES+i] <= 1'b0;
        end
      end
      always_ff @(posedge clk_i) begin
        node_val_q[LEAVES+i] <= '0;
      end
    end
  end

  // at most one cell hits, so an OR merges both halves
  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        node_hit_q[n] <= 1'b0;
      end else begin
        node_hit_q[n] <= node_hit_q[2*n] | node_hit_q[2*n+1];
      end
    end
    always_ff @(posedge clk_i) begin
      node_val_q[n] <= node_val_q[2*n] | node_val_q[2*n+1];
    end
  end

  assign hit_o = node_hit_q[1];
  assign val_o = node_val_q[1];

endmodule

`default_nettype wire

/* rtl/sorted_key_value_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sorted key/value table of up to CAPACITY signed 32-bit pairs, kept in a
// row of cells in ascending key order (cell 0 holds the smallest key).
// Input channel: operation_i, key_i, operand_i with in_valid_i/in_stall_o.
// A transfer happens when valid is high and stall is low.
// Output channel: result_value_o, status_o with out_valid_o/out_stall_i;
// every input transfer yields exactly one output transfer.
// Flow: the key is broadcast to all cells, which compare it at once; a
// registered OR tree of depth log2(CAPACITY) gathers the matching value.
// The apply cycle then writes the cells (overwrite, add, or insert with the
// larger entries shifting up one cell in the same cycle).
// The search state waits while the compare results climb the tree; the apply
// state then loads the result. One item is in flight at a time; a new one is
// taken only once the controller is back in idle, as the result is loaded.
// Reset empties the table (occupancy flags clear) and drops any result.
// A stalled result holds in the output register; the apply step waits for
// it to drain, and in_stall_o stays high meanwhile.

module sorted_key_value_table
  import skvt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              operation_i,
  input  wire logic signed [KEY_W-1:0] key_i,
  input  wire logic signed [VAL_W-1:0] operand_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [VAL_W-1:0]      result_value_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned TREE_LAT = $clog2(CAPACITY) + 1;
  localparam int unsigned CNT_W    = $clog2(TREE_LAT + 1);

  ctrl_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // held command
  logic [1:0]              op_q;
  logic signed [KEY_W-1:0] key_q;
  logic signed [VAL_W-1:0] operand_q;

  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] result_q, result_d;
  logic [1:0]              status_q, status_d;

  cell_cmd_t        cmd;
  cell_link_t       link [CAPACITY];
  cell_link_t       head;
  logic [CAPACITY-1:0] hit;
  logic [VAL_W-1:0] hit_val [CAPACITY];
  logic [CAPACITY-1:0] occ_vec;
  logic             found;
  logic [VAL_W-1:0] found_val;
  logic signed [VAL_W-1:0] sum;
  logic             full;
  logic             in_xfer;
  logic             slot_free;

  // below cell 0 sits a virtual entry smaller than any key
  assign head = '{occ: 1'b0, lt: 1'b1, key: '0, val: '0};

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    skvt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .prev_i    ((j == 0) ? head : link[(j == 0) ? 0 : j-1]),
      .link_o    (link[j]),
      .hit_o     (hit[j]),
      .hit_val_o (hit_val[j])
    );
    assign occ_vec[j] = link[j].occ;
  end

  skvt_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hit_i  (hit),
    .val_i  (hit_val),
    .hit_o  (found),
    .val_o  (found_val)
  );

  assign full       = link[CAPACITY-1].occ;
  assign sum        = $signed(found_val) + operand_q;
  assign in_stall_o = (state_q != STATE_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    result_d    = result_q;
    status_d    = status_q;
    cmd         = '{cmd: CMD_HOLD, key: key_q, val: operand_q};
    case (state_q)
      STATE_IDLE: begin
        if (in_xfer) begin
          state_d = STATE_SEARCH;
          cnt_d   = CNT_W'(TREE_LAT - 1);
        end
      end
      STATE_SEARCH: begin
        // wait for the compare results to climb the tree
        if (cnt_q == '0) begin
          state_d = STATE_APPLY;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      STATE_APPLY: begin
        if (slot_free) begin
          state_d     = STATE_IDLE;
          out_valid_d = 1'b1;
          result_d    = '0;
          status_d    = STATUS_NOT_FOUND;
          case (op_q)
            OP_PUT: begin
              if (found) begin
                cmd.cmd  = CMD_WRITE;
                result_d = operand_q;
                status_d = STATUS_OK;
              end else if (full) begin
                // drop the insert, table unchanged
                status_d = STATUS_FULL;
              end else begin
                cmd.cmd  = CMD_INSERT;
                result_d = operand_q;
                status_d = STATUS_OK;
              end
            end
            OP_ADD: begin
              if (found) begin
                cmd.cmd  = CMD_WRITE;
                cmd.val  = sum;
                result_d = sum;
                status_d = STATUS_OK;
              end
            end
            OP_GET: begin
              if (found) begin
                result_d = found_val;
                status_d = STATUS_OK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = STATE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= operation_i;
      key_q     <= key_i;
      operand_q <= operand_i;
    end
    result_q <= result_d;
    status_q <= status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;

  // occupied cells always form a block starting at cell 0
  a_occ_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ_vec + 1'b1) & occ_vec) == '0)
    else $error("occupancy not contiguous");

  // an insert grows the table by exactly one entry
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.cmd == CMD_INSERT) |=>
      $countones(occ_vec) == $past($countones(occ_vec)) + 1)
    else $error("insert did not add one entry");

  // a result is loaded only from the apply step
  a_out_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == STATE_APPLY))
    else $error("result appeared outside apply");

  // a failed operation reports zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != STATUS_OK) |-> (result_q == '0))
    else $error("nonzero value with failing status");

  // writes to the cells happen only in the apply step
  a_cmd_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.cmd != CMD_HOLD) |-> (state_q == STATE_APPLY))
    else $error("cell command outside apply");

endmodule

`default_nettype wire
